>>> src/pdr1a_pkg.sv
// ----------------------------------------------------------------------------
// pdr1a_pkg
// Shared types and constants for the packed density rank-1 accumulator.
// ----------------------------------------------------------------------------
package pdr1a_pkg;

    localparam int MAX_BASIS_DEF = 64;
    localparam logic [6:0] BASIS_RESET = 7'd64;

    localparam int COEF_W  = 32;
    localparam int ENTRY_W = 64;
    localparam int RIDX_W  = 12;
    // round half away from zero at bit 37 of the Q11.85 magnitude
    localparam int ROUND_SHIFT = 37;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_COEF  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_OVERFLOW   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SETUP,
        S_LOOP,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic clear_state;
        logic rd_issue;
        logic sweep;
        logic setup;
        logic issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic sweep_last;
        logic need_loop;
        logic j_last;
        logic pipe_busy;
        logic out_free;
    } stat_t;

endpackage

>>> src/packed_density_rank1_accumulate.sv
// ----------------------------------------------------------------------------
// packed_density_rank1_accumulate
// Weighted outer-product accumulation into a packed lower-triangular store.
// ----------------------------------------------------------------------------
// Coefficient i: i+1 packed entries, each a read-modify-write, one entry
//   issued per cycle through a six-stage term pipeline, then a drain.
// Read, no-op: straight to the result; a coefficient that updates nothing: setup, then result.
// Clear: one entry zeroed a cycle. A held result adds stall; one transaction at a time.
// Reset: synchronous active-low; a sweep over all STORE_SIZE entries (2080 entries at
//   MAX_BASIS 64) zeroes the store, no transaction accepted until it ends.
module packed_density_rank1_accumulate #(
    parameter int MAX_BASIS = pdr1a_pkg::MAX_BASIS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // coef[31:0], weight[63:32], read_index[75:64], zeros
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    input  logic        s_tlast,   // last_coef
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // entry_value[63:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast,   // orbital_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // basis size
);

    pdr1a_pkg::cmd_t  cmd;
    pdr1a_pkg::stat_t st;

    // register writes are always accepted and registered straight into basis_reg
    assign cfg_ready = 1'b1;

    pdr1a_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pdr1a_datapath #(
        .MAX_BASIS (MAX_BASIS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

>>> src/pdr1a_ctrl.sv
// ----------------------------------------------------------------------------
// pdr1a_ctrl
// Sequencer: store sweep, coefficient setup, row issue, drain and result.
// ----------------------------------------------------------------------------
module pdr1a_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pdr1a_pkg::stat_t  st,
    output pdr1a_pkg::cmd_t   cmd
);

    pdr1a_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdr1a_pkg::S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pdr1a_pkg::S_INIT: begin
                if (st.sweep_last) state_next = pdr1a_pkg::S_IDLE;
            end
            pdr1a_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    unique case (st.in_op)
                        pdr1a_pkg::OP_CLEAR: state_next = pdr1a_pkg::S_CLEAR;
                        pdr1a_pkg::OP_COEF:  state_next = pdr1a_pkg::S_SETUP;
                        default:             state_next = pdr1a_pkg::S_FINISH;
                    endcase
                end
            end
            pdr1a_pkg::S_CLEAR: begin
                if (st.sweep_last) state_next = pdr1a_pkg::S_FINISH;
            end
            pdr1a_pkg::S_SETUP: begin
                state_next = st.need_loop ? pdr1a_pkg::S_LOOP : pdr1a_pkg::S_FINISH;
            end
            pdr1a_pkg::S_LOOP: begin
                if (st.j_last) state_next = pdr1a_pkg::S_DRAIN;
            end
            pdr1a_pkg::S_DRAIN: begin
                if (!st.pipe_busy) state_next = pdr1a_pkg::S_FINISH;
            end
            pdr1a_pkg::S_FINISH: begin
                if (st.out_free) state_next = pdr1a_pkg::S_IDLE;
            end
            default: state_next = pdr1a_pkg::S_INIT;
        endcase
    end

    always_comb begin
        s_tready        = (state_reg == pdr1a_pkg::S_IDLE);
        cmd.accept      = s_tready && s_tvalid;
        cmd.clear_state = cmd.accept && (st.in_op == pdr1a_pkg::OP_CLEAR);
        cmd.rd_issue    = cmd.accept && (st.in_op == pdr1a_pkg::OP_READ);
        cmd.sweep       = (state_reg == pdr1a_pkg::S_INIT) || (state_reg == pdr1a_pkg::S_CLEAR);
        cmd.setup       = (state_reg == pdr1a_pkg::S_SETUP);
        cmd.issue       = (state_reg == pdr1a_pkg::S_LOOP);
        cmd.finish      = (state_reg == pdr1a_pkg::S_FINISH) && st.out_free;
    end

endmodule

>>> src/pdr1a_datapath.sv
// ----------------------------------------------------------------------------
// pdr1a_datapath
// Packed store, coefficient buffer, six-stage scaled-term pipeline with
// saturating read-modify-write, sticky error and output register.
// ----------------------------------------------------------------------------
module pdr1a_datapath #(
    parameter int MAX_BASIS = pdr1a_pkg::MAX_BASIS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [79:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  logic              cfg_valid,
    input  logic [6:0]        cfg_data,
    input  pdr1a_pkg::cmd_t   cmd,
    output pdr1a_pkg::stat_t  st
);

    localparam int STORE_SIZE = MAX_BASIS * (MAX_BASIS + 1) / 2;
    localparam int AW = $clog2(STORE_SIZE);
    localparam int BW = $clog2(MAX_BASIS);
    localparam int CW = $clog2(MAX_BASIS + 1);
    localparam int NW = (CW > 7) ? CW : 7;
    localparam int RW = AW + 1;

    // configuration and latched transaction
    logic [6:0]               basis_reg;
    pdr1a_pkg::op_t           op_reg;
    logic signed [31:0]       c_reg;
    logic signed [31:0]       w_reg;
    logic                     last_reg;
    logic [11:0]              ridx_reg;

    // orbital state
    logic [CW-1:0]            count_reg, count_next;
    logic signed [31:0]       wlat_reg, wlat_next;
    pdr1a_pkg::status_t       err_reg, err_next;

    logic [AW-1:0]            sweep_addr_reg;
    logic [BW-1:0]            j_reg;
    logic [AW-1:0]            row_reg;
    logic [31:0]              mw_reg;
    logic                     wneg_reg;

    // pipeline
    logic                     s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg;
    logic [AW-1:0]            s1_a_reg, s2_a_reg, s3_a_reg, s4_a_reg, s5_a_reg, s6_a_reg;
    logic signed [31:0]       buf_q_reg;
    logic signed [63:0]       p_reg;
    logic [62:0]              mp_reg;
    logic                     neg2_reg, neg3_reg, neg4_reg;
    logic [63:0]              lo_reg;
    logic [62:0]              hi_reg;
    logic [63:0]              m_reg;
    logic [63:0]              term_reg;
    logic [63:0]              rdq_reg;

    // memories
    logic [63:0]              store_mem [STORE_SIZE];
    logic signed [31:0]       buf_mem [MAX_BASIS];

    // output register
    logic                     out_valid_reg;
    logic [63:0]              out_value_reg;
    logic [1:0]               out_status_reg;
    logic                     out_done_reg;

    // combinational
    logic [NW-1:0]            basis_ext, n_wide;
    logic [CW-1:0]            n;
    logic                     i_in_range;
    logic [BW-1:0]            i_idx;
    logic signed [31:0]       wl_eff;
    logic [RW-1:0]            i_ext, row_prod;
    logic [AW-1:0]            row_base;
    logic [CW:0]              i_plus;
    logic                     short_vec;
    logic                     ridx_ok;
    logic signed [63:0]       p_prod;
    logic [63:0]              p_mag;
    logic [63:0]              lo_prod;
    logic [62:0]              hi_prod;
    logic [95:0]              rsum;
    logic signed [64:0]       acc_sum;
    logic                     acc_ovf;
    logic [63:0]              acc_val;
    logic                     st_we;
    logic [AW-1:0]            st_waddr;
    logic [63:0]              st_wdata;
    logic                     st_re;
    logic [AW-1:0]            st_raddr;
    pdr1a_pkg::status_t       fin_err;
    logic                     fin_done;
    logic [63:0]              fin_value;

    always_comb begin
        basis_ext  = NW'(basis_reg);
        n_wide     = (basis_ext > NW'(MAX_BASIS)) ? NW'(MAX_BASIS) : basis_ext;
        n          = n_wide[CW-1:0];
        i_in_range = (count_reg < n);
        i_idx      = count_reg[BW-1:0];
        wl_eff     = (count_reg == '0) ? w_reg : wlat_reg;
        i_ext      = RW'(count_reg);
        row_prod   = i_ext * (i_ext + RW'(1));
        row_base   = row_prod[AW:1];
        i_plus     = {1'b0, count_reg} + (CW+1)'(1);
        short_vec  = last_reg && (i_plus != {1'b0, n});
        ridx_ok    = (32'(ridx_reg) < 32'(STORE_SIZE));
    end

    always_comb begin
        st.in_op      = pdr1a_pkg::op_t'(s_tuser);
        st.sweep_last = (sweep_addr_reg == AW'(STORE_SIZE - 1));
        st.need_loop  = (wl_eff != 0) && i_in_range && (err_reg == pdr1a_pkg::ST_OK);
        st.j_last     = (j_reg == i_idx);
        st.pipe_busy  = s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg || s5_v_reg || s6_v_reg;
        st.out_free   = !out_valid_reg || m_tready;
    end

    // arithmetic per stage
    always_comb begin
        p_prod  = c_reg * buf_q_reg;
        p_mag   = p_reg[63] ? (64'd0 - 64'(p_reg)) : 64'(p_reg);
        lo_prod = mp_reg[31:0] * mw_reg;
        hi_prod = mp_reg[62:32] * mw_reg;
        rsum    = {1'b0, hi_reg, 32'd0} + {32'd0, lo_reg}
                + (96'd1 << (pdr1a_pkg::ROUND_SHIFT - 1));
        acc_sum = {rdq_reg[63], rdq_reg} + {term_reg[63], term_reg};
        acc_ovf = acc_sum[64] ^ acc_sum[63];
        if (acc_ovf) begin
            acc_val = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            acc_val = acc_sum[63:0];
        end
    end

    // result of the transaction in the finish cycle
    always_comb begin
        fin_err = err_reg;
        if ((op_reg == pdr1a_pkg::OP_COEF) && (wlat_reg != 0) && i_in_range && short_vec
            && (err_reg == pdr1a_pkg::ST_OK)) begin
            fin_err = pdr1a_pkg::ST_INCOMPLETE;
        end
        fin_done  = (op_reg == pdr1a_pkg::OP_COEF) && last_reg && (fin_err == pdr1a_pkg::ST_OK);
        fin_value = ((op_reg == pdr1a_pkg::OP_READ) && (err_reg == pdr1a_pkg::ST_OK) && ridx_ok)
                  ? rdq_reg : 64'd0;
    end

    always_comb begin
        err_next = err_reg;
        if (cmd.clear_state) begin
            err_next = pdr1a_pkg::ST_OK;
        end else if (cmd.setup && (wl_eff != 0) && !i_in_range
                     && (err_reg == pdr1a_pkg::ST_OK)) begin
            err_next = pdr1a_pkg::ST_INCOMPLETE;
        end else if (s6_v_reg && acc_ovf && (err_reg == pdr1a_pkg::ST_OK)) begin
            err_next = pdr1a_pkg::ST_OVERFLOW;
        end else if (cmd.finish) begin
            err_next = fin_err;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.clear_state) begin
            count_next = '0;
        end else if (cmd.finish && (op_reg == pdr1a_pkg::OP_COEF)) begin
            if (last_reg) begin
                count_next = '0;
            end else if (i_in_range) begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_comb begin
        wlat_next = wlat_reg;
        if (cmd.clear_state) begin
            wlat_next = '0;
        end else if (cmd.setup) begin
            wlat_next = wl_eff;
        end
    end

    // store port selection: sweep and row update never overlap
    always_comb begin
        st_we    = cmd.sweep || (s6_v_reg && (err_reg == pdr1a_pkg::ST_OK));
        st_waddr = cmd.sweep ? sweep_addr_reg : s6_a_reg;
        st_wdata = cmd.sweep ? 64'd0 : acc_val;
        st_re    = cmd.rd_issue || s5_v_reg;
        st_raddr = cmd.rd_issue ? AW'(s_tdata[75:64]) : s5_a_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            basis_reg      <= pdr1a_pkg::BASIS_RESET;
            count_reg      <= '0;
            wlat_reg       <= '0;
            err_reg        <= pdr1a_pkg::ST_OK;
            sweep_addr_reg <= '0;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            s3_v_reg       <= 1'b0;
            s4_v_reg       <= 1'b0;
            s5_v_reg       <= 1'b0;
            s6_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) basis_reg <= cfg_data;
            count_reg <= count_next;
            wlat_reg  <= wlat_next;
            err_reg   <= err_next;
            if (cmd.sweep) begin
                // wrap to zero so the next sweep starts clean
                sweep_addr_reg <= st.sweep_last ? '0 : sweep_addr_reg + AW'(1);
            end
            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= pdr1a_pkg::op_t'(s_tuser);
            c_reg    <= s_tdata[31:0];
            w_reg    <= s_tdata[63:32];
            last_reg <= s_tlast;
            ridx_reg <= s_tdata[75:64];
        end
        if (cmd.setup) begin
            j_reg    <= '0;
            row_reg  <= row_base;
            wneg_reg <= wl_eff[31];
            mw_reg   <= wl_eff[31] ? (32'd0 - 32'(wl_eff)) : 32'(wl_eff);
        end else if (cmd.issue) begin
            j_reg <= j_reg + BW'(1);
        end
        s1_a_reg <= row_reg + AW'(j_reg);
        s2_a_reg <= s1_a_reg;
        s3_a_reg <= s2_a_reg;
        s4_a_reg <= s3_a_reg;
        s5_a_reg <= s4_a_reg;
        s6_a_reg <= s5_a_reg;
        p_reg    <= p_prod;
        mp_reg   <= p_mag[62:0];
        neg2_reg <= p_reg[63] ^ wneg_reg;
        lo_reg   <= lo_prod;
        hi_reg   <= hi_prod;
        neg3_reg <= neg2_reg;
        m_reg    <= 64'(rsum[95:pdr1a_pkg::ROUND_SHIFT]);
        neg4_reg <= neg3_reg;
        term_reg <= neg4_reg ? (64'd0 - m_reg) : m_reg;
        if (cmd.finish) begin
            out_value_reg  <= fin_value;
            out_status_reg <= fin_err;
            out_done_reg   <= fin_done;
        end
    end

    // coefficient buffer
    always_ff @(posedge aclk) begin
        if (cmd.setup && (wl_eff != 0) && i_in_range) begin
            buf_mem[i_idx] <= c_reg;
        end
        if (cmd.issue) begin
            buf_q_reg <= buf_mem[j_reg];
        end
    end

    // packed store
    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            rdq_reg <= store_mem[st_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_done_reg;

endmodule

>>> sim/density_checker.sv
// ----------------------------------------------------------------------------
// density_checker
// Watches the input, result and configuration channels of the packed density
// accumulator, keeps its own copy of the packed store and flags every result
// that differs from the predicted one.
// ----------------------------------------------------------------------------
module density_checker #(
    parameter int MAX_BASIS = pdr1a_pkg::MAX_BASIS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,   // coef[31:0], weight[63:32], read_index[75:64], zeros
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    input  logic        s_tlast,   // last_coef
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // entry_value[63:0]
    input  logic [1:0]  m_tuser,   // status[1:0]
    input  logic        m_tlast,   // orbital_done
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,  // basis size
    output int          fail_count,
    output int          pending
);

    localparam int STORE_SIZE = MAX_BASIS * (MAX_BASIS + 1) / 2;
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        pdr1a_pkg::status_t status;
        longint             value;
        logic               done;
    } density_reply_t;

    longint             store_mirror [STORE_SIZE];
    int                 coef_mem [MAX_BASIS];
    int unsigned        fill_pos;
    int                 held_weight;
    pdr1a_pkg::status_t sticky_status;
    logic [6:0]         basis_reg;
    int                 result_no;

    density_reply_t density_replies [$];

    function automatic void wipe_mirror();
        foreach (store_mirror[k]) store_mirror[k] = 0;
        fill_pos = 0;
        held_weight = 0;
        sticky_status = pdr1a_pkg::ST_OK;
    endfunction

    function automatic void raise_status(pdr1a_pkg::status_t code);
        if (sticky_status == pdr1a_pkg::ST_OK)
            sticky_status = code;
    endfunction

    // round |p*w| / 2^37 half away from zero, then restore the sign
    function automatic longint rounded_term(longint p, int w);
        logic           neg;
        logic [63:0]    mp;
        logic [31:0]    mw;
        logic [127:0]   mag;
        neg = (p < 0) != (w < 0);
        mp = (p < 0) ? 64'(-p) : 64'(p);
        mw = (w < 0) ? 32'(-w) : 32'(w);
        mag = ({64'd0, mp} * {96'd0, mw} + (128'd1 << (pdr1a_pkg::ROUND_SHIFT - 1)))
              >> pdr1a_pkg::ROUND_SHIFT;
        return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
    endfunction

    function automatic void add_term(int unsigned idx, longint term);
        longint acc;
        acc = store_mirror[idx];
        if (term > 0 && acc > I64_MAX - term) begin
            store_mirror[idx] = I64_MAX;
            raise_status(pdr1a_pkg::ST_OVERFLOW);
        end else if (term < 0 && acc < I64_MIN - term) begin
            store_mirror[idx] = I64_MIN;
            raise_status(pdr1a_pkg::ST_OVERFLOW);
        end else begin
            store_mirror[idx] = acc + term;
        end
    endfunction

    function automatic density_reply_t density_step(pdr1a_pkg::op_t op, int c, int w,
                                                    logic last, logic [11:0] ridx);
        density_reply_t r;
        int unsigned    i;
        int unsigned    n;
        int unsigned    j;
        int unsigned    row;
        longint         p;
        r.status = pdr1a_pkg::ST_OK;
        r.value = 0;
        r.done = 1'b0;
        n = (basis_reg > MAX_BASIS) ? MAX_BASIS : basis_reg;
        case (op)
            pdr1a_pkg::OP_CLEAR: begin
                wipe_mirror();
            end
            pdr1a_pkg::OP_COEF: begin
                i = fill_pos;
                if (i == 0)
                    held_weight = w;
                if (held_weight != 0) begin
                    if (i >= n) begin
                        raise_status(pdr1a_pkg::ST_INCOMPLETE);
                    end else begin
                        coef_mem[i] = c;
                        if (sticky_status == pdr1a_pkg::ST_OK) begin
                            row = i * (i + 1) / 2;
                            for (j = 0; j <= i && sticky_status == pdr1a_pkg::ST_OK; j++) begin
                                p = longint'(c) * longint'(coef_mem[j]);
                                add_term(row + j, rounded_term(p, held_weight));
                            end
                        end
                        if (last && i + 1 != n)
                            raise_status(pdr1a_pkg::ST_INCOMPLETE);
                    end
                end
                if (i < n)
                    fill_pos = i + 1;
                if (last) begin
                    fill_pos = 0;
                    if (sticky_status == pdr1a_pkg::ST_OK)
                        r.done = 1'b1;
                end
            end
            pdr1a_pkg::OP_READ: begin
                if (sticky_status == pdr1a_pkg::ST_OK && ridx < STORE_SIZE)
                    r.value = store_mirror[ridx];
            end
            default: ;
        endcase
        r.status = sticky_status;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("checker: result %0d %s: expected %h, got %h", result_no, what, want, got);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        density_reply_t want;
        if (!aresetn) begin
            wipe_mirror();
            foreach (coef_mem[k]) coef_mem[k] = 0;
            basis_reg = pdr1a_pkg::BASIS_RESET;
            density_replies.delete();
            fail_count = 0;
            result_no = 0;
            pending <= 0;
        end else begin
            // compare before queuing: a result can never stem from this edge's item
            if (m_tvalid && m_tready) begin
                if (density_replies.size() == 0) begin
                    report_mismatch("unexpected transaction", 64'd0, m_tdata);
                end else begin
                    want = density_replies.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 64'(want.status), 64'(m_tuser));
                    if (m_tdata !== want.value)
                        report_mismatch("entry_value", want.value, m_tdata);
                    if (m_tlast !== want.done)
                        report_mismatch("orbital_done", 64'(want.done), 64'(m_tlast));
                end
                result_no++;
            end
            if (cfg_valid && cfg_ready)
                basis_reg = cfg_data;
            if (s_tvalid && s_tready)
                density_replies.insert(density_replies.size(),
                                       density_step(pdr1a_pkg::op_t'(s_tuser),
                                                    $signed(s_tdata[31:0]),
                                                    $signed(s_tdata[63:32]),
                                                    s_tlast, s_tdata[75:64]));
            pending <= density_replies.size();
        end
    end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the packed density accumulator with directed orbitals, saturation
// runs and random orbital streams under several basis sizes, with bursty
// input, a stalling receiver and one long output hold-off. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;    // coef[31:0], weight[63:32], read_index[75:64], zeros
    logic [1:0]  s_tuser = pdr1a_pkg::OP_NOP; // opcode[1:0]
    logic        s_tlast = 1'b0;  // last_coef
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // entry_value[63:0]
    logic [1:0]  m_tuser;         // status[1:0]
    logic        m_tlast;         // orbital_done
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;   // basis size

    int          fail_count;
    int          pending;

    int             items_sent = 0;
    int             basis_now = 64;
    int             burst_left = 0;
    bit             gaps_on = 1'b1;
    pdr1a_pkg::op_t last_op = pdr1a_pkg::OP_NOP;
    logic           hold_request = 1'b0;
    logic           hold_off = 1'b0;

    int          rcv_mode = 0;
    int          rcv_left = 0;
    logic [7:0]  rcv_pattern = 8'hFF;
    logic [2:0]  rcv_phase = '0;

    int          fixed_basis [10] = '{64, 0, 127, 3, 1, 100, 5, 2, 8, 16};

    always #2 aclk = ~aclk;

    packed_density_rank1_accumulate u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    density_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: change stall behavior every stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rcv_left == 0) begin
                rcv_mode <= int'($urandom_range(0, 3));
                rcv_left <= int'($urandom_range(20, 200));
                rcv_pattern <= 8'($urandom);
            end else begin
                rcv_left <= rcv_left - 1;
            end
            rcv_phase <= rcv_phase + 3'd1;
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                case (rcv_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= rcv_pattern[rcv_phase];
                endcase
            end
        end
    end

    // long output hold-off, once, while the sender keeps offering
    initial begin
        wait (hold_request);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #40000000;
        $display("testbench: errors");
        $finish;
    end

    task automatic send_item(pdr1a_pkg::op_t op, logic [31:0] c, logic [31:0] w,
                             logic last, logic [11:0] ridx);
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(40, 120))
                                                     : int'($urandom_range(1, 16));
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, ridx, w, c};
        s_tuser <= op;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        last_op = op;
    endtask

    // drop valid, wait for every result, then let the block drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat ((last_op == pdr1a_pkg::OP_CLEAR) ? 2100 : 80) @(posedge aclk);
    endtask

    task automatic write_basis(logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        basis_now = int'(value);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'd1;
            3: v = 32'hFFFF_FFFF;
            4, 5: v = $signed(v) >>> $urandom_range(4, 28);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] pick_index();
        int eff;
        int i;
        int j;
        eff = (basis_now > 64) ? 64 : basis_now;
        if (eff == 0)
            eff = 1;
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                i = int'($urandom_range(0, eff - 1));
                j = int'($urandom_range(0, i));
                return 12'(i * (i + 1) / 2 + j);
            end
            3: return 12'($urandom_range(0, 2079));
            4: return 12'($urandom_range(2080, 4095));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 12'd0;
                    1: return 12'd2079;
                    2: return 12'd2080;
                    default: return 12'd4095;
                endcase
            end
        endcase
    endfunction

    task automatic send_read(logic [11:0] idx);
        send_item(pdr1a_pkg::OP_READ, $urandom, $urandom, 1'($urandom_range(0, 1)), idx);
    endtask

    task automatic send_clear();
        send_item(pdr1a_pkg::OP_CLEAR, $urandom, $urandom, 1'($urandom_range(0, 1)),
                  12'($urandom));
    endtask

    task automatic send_nop();
        send_item(pdr1a_pkg::OP_NOP, $urandom, $urandom, 1'($urandom_range(0, 1)),
                  12'($urandom));
    endtask

    task automatic send_coef(logic [31:0] c, logic [31:0] w, logic last);
        send_item(pdr1a_pkg::OP_COEF, c, w, last, 12'($urandom));
    endtask

    // shape: 0 well formed, 1 too short, 2 too long, 3 no final coefficient
    task automatic send_orbital(int shape);
        int          eff;
        int          len;
        int          k;
        logic [31:0] w;
        eff = (basis_now > 64) ? 64 : basis_now;
        case (shape)
            0: len = (eff == 0) ? int'($urandom_range(1, 3)) : eff;
            1: len = (eff > 1) ? int'($urandom_range(1, eff - 1)) : 1;
            2: len = eff + int'($urandom_range(1, 3));
            default: len = int'($urandom_range(1, (eff > 0) ? eff : 2));
        endcase
        w = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_value();
        for (k = 0; k < len; k++) begin
            // occasional read or no-op inside the vector
            if ($urandom_range(0, 29) == 0) begin
                if ($urandom_range(0, 1) != 0)
                    send_read(pick_index());
                else
                    send_nop();
            end
            send_coef(pick_value(), (k == 0) ? w : $urandom, shape != 3 && k == len - 1);
        end
    endtask

    task automatic run_segment(logic [6:0] basis);
        int eff;
        int vectors;
        int v;
        int roll;
        int shape;
        settle();
        write_basis(basis);
        send_clear();
        eff = (basis > 64) ? 64 : int'(basis);
        vectors = (eff >= 32) ? 1 : 36 / (eff + 2) + 1;
        for (v = 0; v < vectors; v++) begin
            roll = int'($urandom_range(0, 99));
            shape = (roll < 78) ? 0 : (roll < 85) ? 1 : (roll < 92) ? 2 : 3;
            send_orbital(shape);
            repeat ($urandom_range(0, 3)) send_read(pick_index());
            if ($urandom_range(0, 19) == 0)
                send_nop();
            if ((shape != 0 && $urandom_range(0, 9) < 5) || $urandom_range(0, 49) == 0)
                send_clear();
        end
    endtask

    task automatic directed_checks();
        settle();
        write_basis(7'd2);
        send_read(12'd0);
        send_read(12'd2079);
        send_read(12'd4095);
        send_item(pdr1a_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 12'hFFF);
        // extreme coefficients and weight
        send_coef(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_coef(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_read(12'd0);
        send_read(12'd1);
        send_read(12'd2);
        // zero weight: no length check, still done
        send_coef(32'h1000_0000, 32'd0, 1'b0);
        send_coef(32'h2000_0000, 32'd0, 1'b0);
        send_coef(32'h3000_0000, 32'd0, 1'b1);
        // too short, then a second error that must not replace the first
        send_coef(32'h1000_0000, 32'h2000_0000, 1'b1);
        send_read(12'd0);
        send_coef(32'h1000_0000, 32'h2000_0000, 1'b1);
        send_clear();
        send_read(12'd0);
        // too long
        send_coef(32'h0800_0000, 32'h7FFF_FFFF, 1'b0);
        send_coef(32'hF800_0000, 32'h7FFF_FFFF, 1'b0);
        send_coef(32'h0800_0000, 32'h7FFF_FFFF, 1'b1);
        send_read(12'd2);
        send_clear();
    endtask

    // drive entry zero to both saturation limits with one-coefficient vectors
    task automatic saturation_checks();
        settle();
        write_basis(7'd1);
        send_clear();
        repeat (129) send_coef(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_read(12'd0);
        send_clear();
        // 128 terms land exactly on the negative limit, the next one saturates
        repeat (128) send_coef(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_read(12'd0);
        send_coef(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_read(12'd0);
        send_coef(32'h4000_0000, 32'h2000_0000, 1'b0);
        send_coef(32'h4000_0000, 32'h2000_0000, 1'b1);
        send_clear();
        send_read(12'd0);
    endtask

    // hold the receiver off while reads keep coming without gaps
    task automatic output_pressure();
        int k;
        gaps_on = 1'b0;
        hold_request <= 1'b1;
        for (k = 0; k < 60; k++)
            send_read(pick_index());
        gaps_on = 1'b1;
    endtask

    initial begin
        int s;
        int roll;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        directed_checks();
        saturation_checks();
        for (s = 0; s < 10; s++) begin
            run_segment(7'(fixed_basis[s]));
            if (s == 3)
                output_pressure();
        end
        while (items_sent < 1550) begin
            roll = int'($urandom_range(0, 99));
            if (roll < 80)
                run_segment(7'($urandom_range(1, 6)));
            else if (roll < 95)
                run_segment(7'($urandom_range(7, 20)));
            else
                run_segment(7'($urandom_range(21, 64)));
        end
        settle();
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
